### rtl/ridl_pkg.sv
`default_nettype none

package ridl_pkg;

  // Fixed widths of the request and result fields.
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;         // latch the incoming request
    logic load_cursor;  // set the shift cursor at the start of a move
    logic rd_shift;     // read the neighbour of the cursor
    logic wr_shift;     // write the moved entry at the cursor
    logic wr_val;       // write the new word at the requested position
    logic finish;       // update the count and present the result
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_ins;
    logic is_rd;
    logic ok;           // the latched request passes its checks
    logic ins_append;   // insert lands at the end, nothing to move
    logic del_last;     // delete of the last entry, nothing to move
    logic shift_done;   // the current move is the last one
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/ridl_ram.sv
`default_nettype none

module ridl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/ridl_ctrl.sv
`default_nettype none

module ridl_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire ridl_pkg::dp_stat_t    stat_i,
  output ridl_pkg::ctrl_cmd_t        cmd_o,
  output logic                       busy_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVAL  = 6'b000010,
    S_SH_RD = 6'b000100,
    S_SH_WR = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!stat_i.ok || stat_i.is_rd) begin
          state_d = S_DONE;
        end else if (stat_i.is_ins) begin
          if (stat_i.ins_append) begin
            state_d = S_WRITE;
          end else begin
            cmd_o.load_cursor = 1'b1;
            state_d           = S_SH_RD;
          end
        end else begin
          cmd_o.load_cursor = 1'b1;
          state_d           = stat_i.del_last ? S_DONE : S_SH_RD;
        end
      end
      S_SH_RD: begin
        cmd_o.rd_shift = 1'b1;
        state_d        = S_SH_WR;
      end
      S_SH_WR: begin
        cmd_o.wr_shift = 1'b1;
        if (stat_i.shift_done) begin
          state_d = stat_i.is_ins ? S_WRITE : S_DONE;
        end else begin
          state_d = S_SH_RD;
        end
      end
      S_WRITE: begin
        cmd_o.wr_val = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

### rtl/ridl_dp.sv
`default_nettype none

module ridl_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic [ridl_pkg::CMD_W-1:0]           command_i,
  input  wire logic [ridl_pkg::POS_W-1:0]           position_i,
  input  wire logic signed [ridl_pkg::DATA_W-1:0]   value_i,
  input  wire ridl_pkg::ctrl_cmd_t                  cmd_i,
  output ridl_pkg::dp_stat_t                        stat_o,
  output logic                                      done_o,
  output logic signed [ridl_pkg::DATA_W-1:0]        read_value_o,
  output logic [1:0]                                status_o,
  output logic [ridl_pkg::CNT_W-1:0]                count_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > ridl_pkg::POS_W) ? CW : ridl_pkg::POS_W;

  ridl_pkg::cmd_e                   cmd_q;
  logic [ridl_pkg::POS_W-1:0]       pos_q;
  logic [ridl_pkg::DATA_W-1:0]      val_q;
  logic [CW-1:0]                    count_q, count_d;
  logic [AW-1:0]                    cursor_q;

  logic [CMPW-1:0]                  count_x, pos_x, cursor_x;
  ridl_pkg::status_e                status;
  logic                             ok;

  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr, ram_raddr;
  logic [ridl_pkg::DATA_W-1:0]      ram_wdata, ram_rdata;

  logic                             done_q;
  logic [ridl_pkg::DATA_W-1:0]      rd_val_q;
  ridl_pkg::status_e                status_q;
  logic [CW-1:0]                    res_count_q;
  logic [CMPW-1:0]                  res_count_x;

  assign count_x  = CMPW'(count_q);
  assign pos_x    = CMPW'(pos_q);
  assign cursor_x = CMPW'(cursor_q);

  always_comb begin
    unique case (cmd_q)
      ridl_pkg::CMD_INSERT: begin
        if (count_x == CMPW'(DEPTH)) begin
          status = ridl_pkg::ST_FULL;
        end else if (pos_x > count_x) begin
          status = ridl_pkg::ST_RANGE;
        end else begin
          status = ridl_pkg::ST_OK;
        end
      end
      ridl_pkg::CMD_DELETE: begin
        if (count_x == '0) begin
          status = ridl_pkg::ST_EMPTY;
        end else if (pos_x >= count_x) begin
          status = ridl_pkg::ST_RANGE;
        end else begin
          status = ridl_pkg::ST_OK;
        end
      end
      ridl_pkg::CMD_READ: begin
        status = (pos_x < count_x) ? ridl_pkg::ST_OK : ridl_pkg::ST_RANGE;
      end
      default: begin
        status = ridl_pkg::ST_RANGE;
      end
    endcase
  end

  assign ok = (status == ridl_pkg::ST_OK);

  always_comb begin
    stat_o            = '0;
    stat_o.is_ins     = (cmd_q == ridl_pkg::CMD_INSERT);
    stat_o.is_rd      = (cmd_q == ridl_pkg::CMD_READ);
    stat_o.ok         = ok;
    stat_o.ins_append = (pos_x == count_x);
    stat_o.del_last   = (pos_x == count_x - CMPW'(1));
    stat_o.shift_done = stat_o.is_ins ? (cursor_x - CMPW'(1) == pos_x)
                                      : (cursor_x + CMPW'(1) == count_x - CMPW'(1));
  end

  // Read port: the neighbour of the cursor while moving, otherwise the
  // requested position (this serves a plain read).
  always_comb begin
    if (cmd_i.rd_shift) begin
      ram_raddr = (cmd_q == ridl_pkg::CMD_INSERT) ? cursor_q - AW'(1)
                                                   : cursor_q + AW'(1);
    end else begin
      ram_raddr = pos_x[AW-1:0];
    end
  end

  assign ram_we    = cmd_i.wr_shift | cmd_i.wr_val;
  assign ram_waddr = cmd_i.wr_val ? pos_x[AW-1:0] : cursor_q;
  assign ram_wdata = cmd_i.wr_val ? val_q : ram_rdata;

  ridl_ram #(
    .WIDTH (ridl_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    count_d = count_q;
    if (ok && (cmd_q == ridl_pkg::CMD_INSERT)) begin
      count_d = count_q + CW'(1);
    end else if (ok && (cmd_q == ridl_pkg::CMD_DELETE)) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      cmd_q <= ridl_pkg::cmd_e'(command_i);
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (cmd_i.load_cursor) begin
      cursor_q <= (cmd_q == ridl_pkg::CMD_INSERT) ? count_x[AW-1:0] : pos_x[AW-1:0];
    end else if (cmd_i.wr_shift) begin
      cursor_q <= (cmd_q == ridl_pkg::CMD_INSERT) ? cursor_q - AW'(1)
                                                   : cursor_q + AW'(1);
    end
    if (cmd_i.finish) begin
      rd_val_q    <= (ok && (cmd_q == ridl_pkg::CMD_READ)) ? ram_rdata : '0;
      status_q    <= status;
      res_count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.finish) begin
        count_q <= count_d;
      end
    end
  end

  assign res_count_x  = CMPW'(res_count_q);
  assign done_o       = done_q;
  assign read_value_o = rd_val_q;
  assign status_o     = status_q;
  assign count_o      = res_count_x[ridl_pkg::CNT_W-1:0];

endmodule

`default_nettype wire

### rtl/indexed_insert_delete_list.sv
`default_nettype none

// Ordered list of signed 32-bit words with room for DEPTH entries, held in a
// single-port-write, registered-read RAM. A request is taken when start is
// high and busy is low; it may be an insert, a delete or a read at a list
// position. Each request gives exactly one result, shown on read_value_o,
// status_o and count_o for a single cycle while done_o is high; the receiver
// cannot hold a result off, so it must take it in that cycle. Entries are
// moved one at a time through the RAM port, each by a read state and then a
// write state, so the time from one accepted request to the next depends
// on the work: a read or a rejected request moves no entries, an insert at
// position p into a list of n entries moves n - p of them, and a delete at
// position p moves n - 1 - p. The result appears in the cycle in which busy
// drops, so a new request may be given while it is shown. The RAM needs no
// clearing after reset: only entries below the count are ever read.
module indexed_insert_delete_list #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [ridl_pkg::CMD_W-1:0]          command_i,
  input  wire logic [ridl_pkg::POS_W-1:0]          position_i,
  input  wire logic signed [ridl_pkg::DATA_W-1:0]  value_i,
  output logic                                     done_o,
  output logic signed [ridl_pkg::DATA_W-1:0]       read_value_o,
  output logic [1:0]                               status_o,
  output logic [ridl_pkg::CNT_W-1:0]               count_o
);

  ridl_pkg::ctrl_cmd_t ctrl_cmd;
  ridl_pkg::dp_stat_t  dp_stat;

  // The controller sequences each request; the datapath holds the count,
  // the shift cursor, the RAM and the result registers.
  ridl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (dp_stat),
    .cmd_o  (ctrl_cmd),
    .busy_o (busy)
  );

  ridl_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .command_i    (command_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .cmd_i        (ctrl_cmd),
    .stat_o       (dp_stat),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .count_o      (count_o)
  );

  // An accepted request keeps the block busy in the following cycle.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after a request was taken");

  // Results are only shown once the controller has gone back to idle.
  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  // A result that is not a good read carries a zero word.
  a_zero_unless_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ridl_pkg::ST_OK)) |-> (read_value_o == '0))
    else $error("rejected request returned a non-zero word");

  // The RAM is never written at the same time as a result is finished.
  a_no_write_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.finish |-> !(ctrl_cmd.wr_shift || ctrl_cmd.wr_val))
    else $error("RAM write during result cycle");

endmodule

`default_nettype wire
